// ===== design/linear_probe_hash_table_unit_assert.svh =====
// assertion macros for the hash table unit
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define LPH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define LPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/lpht_pkg.sv =====
// package with codes and types for the hash table unit
package lpht_pkg;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic [63:0] HASH_SEED = 64'd5381;
   localparam logic [31:0] NO_VALUE  = 32'hFFFF_FFFF;

   // control sequencer states
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_HASH  = 7'b0000010,
      S_MOD   = 7'b0000100,
      S_READ  = 7'b0001000,
      S_CHECK = 7'b0010000,
      S_WRITE = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

endpackage

// ===== design/linear_probe_hash_table_unit.sv =====
// hash table with linear probing over a slot memory
// Usage: a request item (operation, key bytes, key length, value) enters on
// req_valid/req_ready; one response item (result value, status) leaves on
// rsp_valid/rsp_ready. csr_write_enable sets the table capacity; the user
// must write it only while idle, the block itself does not enforce this.
// One item at a time: the djb2 hash folds in one key byte per cycle, the
// modulo by the capacity reduces one hash bit per cycle over all 64 bits,
// then the probe walk reads and compares slot by slot (S_READ, then S_CHECK)
// up to capacity slots; an insert that finds a free slot or a delete that
// hits adds a write in S_WRITE; an insert into a full table skips the walk.
// The next request is taken only after the response has been taken.
// Reset empties all slots at once through per-slot used bits, clears the
// entry count and sets the capacity to the largest size.
// The response is held in an output register; while rsp_ready is low the
// response stays and no new request is taken. Key, length and value store
// contents are undefined until written and read only behind a used bit.
module linear_probe_hash_table_unit
   import lpht_pkg::*;
#(
   parameter int MAX_SLOTS     = 256,
   parameter int MAX_KEY_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [63:0] req_key_bytes,
   input  logic [3:0]  req_key_length,
   input  logic [31:0] req_entry_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_value,
   output logic [1:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic [8:0]  csr_write_data
);

   localparam int AW = $clog2(MAX_SLOTS);
   localparam int CW = AW + 1;
   localparam int LW = $clog2(MAX_KEY_BYTES + 1);

   // slot store
   logic [63:0]    mem_key   [MAX_SLOTS];
   logic [LW-1:0]  mem_len   [MAX_SLOTS];
   logic [31:0]    mem_value [MAX_SLOTS];
   logic [MAX_SLOTS-1:0] used_ff;
   logic [63:0]    rd_key_ff;
   logic [LW-1:0]  rd_len_ff;
   logic [31:0]    rd_value_ff;
   logic           rd_used_ff;

   state_type   state_ff, state_in;
   logic [8:0]  cap_reg_ff;
   logic [CW-1:0] count_ff;
   logic [1:0]  op_ff;
   logic [63:0] key_ff;
   logic [LW-1:0] len_ff;
   logic [31:0] val_ff;
   logic [63:0] hash_ff;
   logic [LW-1:0] byte_ff;
   logic [6:0]  bit_ff;
   logic [CW-1:0] rem_ff;
   logic [AW-1:0] idx_ff;
   logic [CW-1:0] probes_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;
   logic [1:0]  rsp_status_ff;

   // live capacity and request key trimming
   logic [CW-1:0] cap;
   logic [LW-1:0] req_len;
   logic [63:0]   req_key;
   logic [CW:0]   rem_shift;
   logic          hit;
   logic [AW-1:0] idx_next;

   always_comb begin
      if (cap_reg_ff == 9'd0) begin
         cap = CW'(1);
      end else if ({23'd0, cap_reg_ff} > MAX_SLOTS) begin
         cap = CW'(MAX_SLOTS);
      end else begin
         cap = CW'(cap_reg_ff);
      end
      if (req_key_length > 4'(MAX_KEY_BYTES)) begin
         req_len = LW'(MAX_KEY_BYTES);
      end else begin
         req_len = LW'(req_key_length);
      end
      for (int b = 0; b < 8; b++) begin
         req_key[b*8 +: 8] = (b < int'(req_len)) ? req_key_bytes[b*8 +: 8] : 8'd0;
      end
      rem_shift = {rem_ff, hash_ff[63 - bit_ff[5:0]]};
      hit = rd_used_ff && (rd_len_ff == len_ff) && (rd_key_ff == key_ff);
      idx_next = ({1'b0, idx_ff} + CW'(1) == cap) ? '0 : idx_ff + AW'(1);
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid && req_ready) state_in = S_HASH;
         S_HASH:  if (byte_ff == len_ff) state_in = S_MOD;
         S_MOD:   if (bit_ff == 7'd63) begin
            state_in = (op_ff == OP_INSERT && count_ff >= cap) ? S_OUT : S_READ;
         end
         S_READ:  state_in = S_CHECK;
         S_CHECK: begin
            if (op_ff == OP_INSERT) begin
               state_in = !rd_used_ff ? S_WRITE :
                          (probes_ff + CW'(1) == cap) ? S_OUT : S_READ;
            end else if (!rd_used_ff || hit || probes_ff + CW'(1) == cap) begin
               state_in = (hit && op_ff == OP_DELETE) ? S_WRITE : S_OUT;
            end else begin
               state_in = S_READ;
            end
         end
         S_WRITE: state_in = S_OUT;
         S_OUT:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_reg_ff   <= 9'd256;
         count_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) cap_reg_ff <= csr_write_data;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == S_WRITE) begin
            used_ff[idx_ff] <= (op_ff == OP_INSERT);
            if (op_ff == OP_INSERT) count_ff <= count_ff + CW'(1);
            else if (count_ff != '0) count_ff <= count_ff - CW'(1);
         end
         if (state_ff == S_OUT) rsp_valid_ff <= 1'b1;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            op_ff   <= req_operation;
            key_ff  <= req_key;
            len_ff  <= req_len;
            val_ff  <= req_entry_value;
            hash_ff <= HASH_SEED;
            byte_ff <= '0;
            bit_ff  <= '0;
            rem_ff  <= '0;
            probes_ff <= '0;
            rsp_value_ff  <= NO_VALUE;
            rsp_status_ff <= ST_DONE;
         end
         S_HASH: if (byte_ff != len_ff) begin
            hash_ff <= (hash_ff << 5) + hash_ff + 64'(key_ff[byte_ff[2:0]*8 +: 8]);
            byte_ff <= byte_ff + LW'(1);
         end
         S_MOD: begin
            rem_ff <= (rem_shift >= {1'b0, cap}) ? CW'(rem_shift - {1'b0, cap})
                                                  : CW'(rem_shift);
            bit_ff <= bit_ff + 7'd1;
            if (op_ff == OP_INSERT && count_ff >= cap && bit_ff == 7'd63) begin
               rsp_status_ff <= ST_FULL;
            end
            if (bit_ff == 7'd63) begin
               idx_ff <= (rem_shift >= {1'b0, cap}) ? AW'(rem_shift - {1'b0, cap})
                                                     : AW'(rem_shift);
            end
         end
         S_READ: ;
         S_CHECK: begin
            probes_ff <= probes_ff + CW'(1);
            if (op_ff == OP_INSERT) begin
               if (rd_used_ff) begin
                  idx_ff <= idx_next;
                  if (probes_ff + CW'(1) == cap) rsp_status_ff <= ST_FULL;
               end
            end else if (hit) begin
               if (op_ff == OP_LOOKUP) rsp_value_ff <= rd_value_ff;
            end else if (!rd_used_ff || probes_ff + CW'(1) == cap) begin
               rsp_status_ff <= (op_ff == OP_LOOKUP || op_ff == OP_DELETE) ? ST_MISSING
                                                                           : ST_DONE;
            end else begin
               idx_ff <= idx_next;
            end
         end
         S_WRITE: ;
         S_OUT: ;
         default: ;
      endcase
   end

   // operation three walks like a lookup but never writes and answers -1, done

   // slot memory: one read or write per cycle, registered read data
   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         rd_key_ff   <= mem_key[idx_ff];
         rd_len_ff   <= mem_len[idx_ff];
         rd_value_ff <= mem_value[idx_ff];
         rd_used_ff  <= used_ff[idx_ff];
      end
      if (state_ff == S_WRITE && op_ff == OP_INSERT) begin
         mem_key[idx_ff]   <= key_ff;
         mem_len[idx_ff]   <= len_ff;
         mem_value[idx_ff] <= val_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

`include "linear_probe_hash_table_unit_assert.svh"

   `LPH_ASSERT_IMPL(a_busy_no_accept, clock, reset, state_ff != S_IDLE, !req_ready)
   `LPH_ASSERT_NEXT(a_out_gives_rsp, clock, reset, state_ff == S_OUT, rsp_valid)
   `LPH_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_SLOTS))

endmodule
